@@ rtl/core/mmn_pkg.sv @@
// Shared types and constants of the min/max axis normaliser.
package mmn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_W      = 16;
  localparam int OUT_W       = 24;
  localparam int NUM_AXES    = 3;
  localparam int DIFF_W      = SAMPLE_BITS + 2;
  localparam int SPAN_W      = SAMPLE_BITS + 1;
  localparam int MAG_W       = SPAN_W + GAIN_W;
  localparam int CNT_W       = $clog2(MAG_W);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_EXTREMES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_GAIN = 1'd1;
  localparam logic [GAIN_W-1:0]    GAIN_RESET          = 16'd256;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic [NUM_AXES-1:0]     zero_span_flags;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic seed;
    logic hold;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm;
    logic                    zero;
  } lane_res_t;

endpackage

@@ rtl/core/minmax_axis_normalizer.sv @@
// Top level of the min/max axis normaliser: configuration, lanes and merge.
//
// Input channel in_valid/in_stall/in_data carries one request: a raw signed
// x/y/z sample. Output channel out_valid/out_stall/out_data returns one
// request per sample: three normalised 24-bit values and zero-span flags.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata):
// index 0 freezes min/max tracking, index 1 sets the full-scale gain.
//
// Each axis has its own lane. A lane updates its extremes, forms the
// centred difference, multiplies by the gain and divides by the span with
// a restoring divider that resolves one quotient bit per cycle. The steps
// run in order: tracking at the accepting edge, then centring, the
// multiply, 33 divide steps (a zero span skips them), saturation and the
// move into the output register. A new sample is accepted once all three
// lanes are idle again, so no sample enters while another is in work.
//
// Reset clears the configuration to hold 0 and gain 256 and forgets the
// extremes; the next sample seeds them. While the receiver stalls the
// finished request stays in the output register; the lanes may take one
// more sample and park in their done state until the register frees.
module minmax_axis_normalizer
  import mmn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic              hold_r, hold_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic              seeded_r, seeded_nxt;
  logic              accept;
  logic              ack;
  logic              all_idle;
  logic              all_done;
  lane_ctrl_t        ctrl;
  lane_stat_t        stat_x, stat_y, stat_z;
  lane_res_t         res_x, res_y, res_z;

  // Accept a new sample only when every lane has handed its result on.
  assign all_idle = stat_x.idle && stat_y.idle && stat_z.idle;
  assign all_done = stat_x.done && stat_y.done && stat_z.done;
  assign in_stall = !all_idle;
  assign accept   = in_valid && all_idle;

  always_comb begin
    hold_nxt   = hold_r;
    gain_nxt   = gain_r;
    seeded_nxt = seeded_r || accept;
    if (cfg_we) begin
      case (cfg_index)
        REG_HOLD_EXTREMES:   hold_nxt = cfg_wdata[0];
        REG_FULL_SCALE_GAIN: gain_nxt = cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= 1'b0;
      gain_r   <= GAIN_RESET;
      seeded_r <= 1'b0;
    end else begin
      hold_r   <= hold_nxt;
      gain_r   <= gain_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  // The first sample seeds both extremes of every axis, hold or not.
  assign ctrl.start = accept;
  assign ctrl.seed  = !seeded_r;
  assign ctrl.hold  = hold_r;
  assign ctrl.ack   = ack;

  mmn_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .gain   (gain_r),
    .sample (in_data.sample_x),
    .stat   (stat_x),
    .res    (res_x)
  );

  mmn_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .gain   (gain_r),
    .sample (in_data.sample_y),
    .stat   (stat_y),
    .res    (res_y)
  );

  mmn_lane u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .gain   (gain_r),
    .sample (in_data.sample_z),
    .stat   (stat_z),
    .res    (res_z)
  );

  mmn_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .all_done  (all_done),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .ack       (ack),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Accepted sample sets every lane working in the next cycle.
  a_lanes_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !stat_x.idle && !stat_y.idle && !stat_z.idle)
    else $error("lanes did not start on an accepted sample");

  // Hand results on only when all three lanes have finished.
  a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
    ack |-> all_done)
    else $error("merge took results from an unfinished lane");

  // Once seeded, the extremes stay seeded until reset.
  a_seeded_holds: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped without reset");

  // A zero-span flag comes with a zero value on that axis.
  a_zero_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_span_flags[0] |-> out_data.norm_x == '0)
    else $error("x flagged zero span but value is not zero");

endmodule

@@ rtl/core/mmn_lane.sv @@
// One axis lane: min/max tracking, scaling multiply and bit-serial divide.
module mmn_lane
  import mmn_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  lane_ctrl_t                    ctrl,
  input  logic        [GAIN_W-1:0]      gain,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output lane_stat_t                    stat,
  output lane_res_t                     res
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_DIV, S_SAT, S_DONE
  } state_t;

  localparam logic [MAG_W-1:0] SAT_POS = MAG_W'((1 << (OUT_W - 1)) - 1);
  localparam logic [MAG_W-1:0] SAT_NEG = MAG_W'(1 << (OUT_W - 1));
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAG_W - 1);

  state_t                        state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic signed [SAMPLE_BITS-1:0] v_r, v_nxt;
  logic        [SPAN_W-1:0]      dmag_r, dmag_nxt;
  logic        [SPAN_W-1:0]      span_r, span_nxt;
  logic                          neg_r, neg_nxt;
  logic                          zero_r, zero_nxt;
  logic        [MAG_W-1:0]       quo_r, quo_nxt;
  logic        [SPAN_W-1:0]      rem_r, rem_nxt;
  logic        [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic signed [OUT_W-1:0]       norm_r, norm_nxt;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] span_full;
  logic        [DIFF_W-1:0] diff_abs;
  logic        [SPAN_W:0]   shifted;
  logic        [SPAN_W:0]   trial;
  logic                     fits;

  always_comb begin
    diff      = (DIFF_W'(v_r) <<< 1) - DIFF_W'(min_r) - DIFF_W'(max_r);
    span_full = DIFF_W'(max_r) - DIFF_W'(min_r);
    diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    shifted   = {rem_r, quo_r[MAG_W-1]};
    trial     = shifted - {1'b0, span_r};
    fits      = shifted >= {1'b0, span_r};
  end

  always_comb begin
    state_nxt = state_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    v_nxt     = v_r;
    dmag_nxt  = dmag_r;
    span_nxt  = span_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    norm_nxt  = norm_r;
    case (state_r)
      S_IDLE: begin
        if (ctrl.start) begin
          v_nxt = sample;
          if (ctrl.seed) begin
            min_nxt = sample;
            max_nxt = sample;
          end else if (!ctrl.hold) begin
            if (sample > max_r) begin
              max_nxt = sample;
            end else if (sample < min_r) begin
              min_nxt = sample;
            end
          end
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        dmag_nxt  = diff_abs[SPAN_W-1:0];
        neg_nxt   = diff[DIFF_W-1];
        span_nxt  = span_full[SPAN_W-1:0];
        zero_nxt  = (span_full == '0);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // zero span skips the divide and reads out as zero
        quo_nxt   = zero_r ? '0 : MAG_W'(dmag_r) * MAG_W'(gain);
        rem_nxt   = '0;
        cnt_nxt   = CNT_TOP;
        state_nxt = zero_r ? S_SAT : S_DIV;
      end
      S_DIV: begin
        rem_nxt = fits ? trial[SPAN_W-1:0] : shifted[SPAN_W-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (neg_r) begin
          norm_nxt = (quo_r > SAT_NEG) ? OUT_W'(SAT_NEG) : -$signed(quo_r[OUT_W-1:0]);
        end else begin
          norm_nxt = (quo_r > SAT_POS) ? OUT_W'(SAT_POS) : $signed(quo_r[OUT_W-1:0]);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ctrl.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    min_r  <= min_nxt;
    max_r  <= max_nxt;
    v_r    <= v_nxt;
    dmag_r <= dmag_nxt;
    span_r <= span_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    norm_r <= norm_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign res.norm  = norm_r;
  assign res.zero  = zero_r;

endmodule

@@ rtl/core/mmn_merge.sv @@
// Merge of the three lane results into the registered output request.
module mmn_merge
  import mmn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        all_done,
  input  lane_res_t   res_x,
  input  lane_res_t   res_y,
  input  lane_res_t   res_z,
  output logic        ack,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic      valid_r, valid_nxt;
  out_item_t data_r, data_nxt;

  always_comb begin
    ack       = all_done && (!valid_r || !out_stall);
    valid_nxt = ack || (valid_r && out_stall);
    data_nxt  = data_r;
    if (ack) begin
      data_nxt.norm_x          = res_x.norm;
      data_nxt.norm_y          = res_y.norm;
      data_nxt.norm_z          = res_z.norm;
      data_nxt.zero_span_flags = {res_z.zero, res_y.zero, res_x.zero};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ sim/tb_minmax_axis_normalizer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the min/max axis normaliser with its own calibration predictor.
module tb_minmax_axis_normalizer;
  import mmn_pkg::*;

  // Ports run on a 10 ns clock. Drive at the falling edge; sample at the rising edge.
  localparam int CYCLE_LIMIT     = 600000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int REPORT_CAP      = 100;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_HOLD_EXTREMES;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the block's state and configuration.
  logic signed [SAMPLE_BITS-1:0] trk_min [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] trk_max [NUM_AXES];
  logic                          extremes_seeded = 1'b0;
  logic                          freeze_extremes = 1'b0;
  logic [GAIN_W-1:0]             gain_setting    = GAIN_RESET;

  // Normalised requests still owed by the block, oldest first.
  out_item_t pending_norms [$];

  int mismatch_count = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int cfg_writes     = 0;
  int feed_gap_pct   = 0;   // chance per cycle that the sender idles
  int drain_gap_pct  = 0;   // chance per cycle that the receiver stalls
  logic holding_off  = 1'b0;
  event hold_off_go;

  minmax_axis_normalizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: no correct run comes anywhere near this.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("minmax_axis_normalizer verification failed");
    $finish;
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < REPORT_CAP) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Track the extremes as the block does, then centre and scale each axis.
  // The quotient truncates toward zero and saturates to the 24-bit range;
  // a zero span yields 0 and raises the axis flag.
  function automatic out_item_t calibrate_sample(in_item_t s);
    logic signed [SAMPLE_BITS-1:0] v [NUM_AXES];
    logic signed [OUT_W-1:0]       n [NUM_AXES];
    logic [NUM_AXES-1:0]           flags;
    longint                        span, num, q;
    int                            a;
    out_item_t                     r;
    v[0] = s.sample_x;
    v[1] = s.sample_y;
    v[2] = s.sample_z;
    flags = '0;
    if (!extremes_seeded) begin
      // The first sample seeds both extremes, hold or not.
      for (a = 0; a < NUM_AXES; a++) begin
        trk_min[a] = v[a];
        trk_max[a] = v[a];
      end
      extremes_seeded = 1'b1;
    end else if (!freeze_extremes) begin
      for (a = 0; a < NUM_AXES; a++) begin
        if (v[a] > trk_max[a]) trk_max[a] = v[a];
        else if (v[a] < trk_min[a]) trk_min[a] = v[a];
      end
    end
    for (a = 0; a < NUM_AXES; a++) begin
      span = longint'(trk_max[a]) - longint'(trk_min[a]);
      if (span == 0) begin
        n[a] = '0;
        flags[a] = 1'b1;
      end else begin
        num = (2 * longint'(v[a]) - longint'(trk_min[a]) - longint'(trk_max[a]))
              * longint'(gain_setting);
        q = num / span;
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        n[a] = OUT_W'(q);
      end
    end
    r.norm_x = n[0];
    r.norm_y = n[1];
    r.norm_z = n[2];
    r.zero_span_flags = flags;
    return r;
  endfunction

  // Offer one request and hold it until accepted. Enter and leave at a
  // falling edge; valid stays high afterwards so back-to-back requests
  // never drop it within one step.
  task automatic send_sample(in_item_t s);
    while ($urandom_range(99) < feed_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_norms.push_back(calibrate_sample(s));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_xyz(int x, int y, int z);
    in_item_t s;
    s.sample_x = SAMPLE_BITS'(x);
    s.sample_y = SAMPLE_BITS'(y);
    s.sample_z = SAMPLE_BITS'(z);
    send_sample(s);
  endtask

  // Drop valid, let every owed request come back, then allow the pipeline
  // its full latency before anything touches the registers.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_norms.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_HOLD_EXTREMES) freeze_extremes = value[0];
    else if (idx == REG_FULL_SCALE_GAIN) gain_setting = value;
    cfg_writes++;
  endtask

  // Only bit 0 of the hold register counts; scramble the rest.
  task automatic set_hold(logic h);
    logic [CFG_DATA_W-1:0] value;
    value = CFG_DATA_W'($urandom);
    value[0] = h;
    write_register(REG_HOLD_EXTREMES, value);
  endtask

  // Mostly full-range noise, with extremes and near-zero readings mixed in.
  function automatic logic signed [SAMPLE_BITS-1:0] random_axis();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh8001;
          default: return 16'sh7ffe;
        endcase
      end
      1: return SAMPLE_BITS'(int'($urandom_range(64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Receiver: stall at random, or solidly during a hold-off.
  always @(negedge clk) begin
    out_stall <= holding_off || ($urandom_range(99) < drain_gap_pct);
  end

  // Hold-off stretch, counted on its own so the sender keeps offering.
  initial forever begin
    @(hold_off_go);
    @(posedge clk);
    holding_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    holding_off = 1'b0;
  end

  // Compare each accepted result with the oldest owed request.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_norms.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: %h", out_data));
      end else begin
        want = pending_norms.pop_front();
        if (out_data.norm_x !== want.norm_x)
          report_mismatch($sformatf("norm_x got %0d want %0d", out_data.norm_x, want.norm_x));
        if (out_data.norm_y !== want.norm_y)
          report_mismatch($sformatf("norm_y got %0d want %0d", out_data.norm_y, want.norm_y));
        if (out_data.norm_z !== want.norm_z)
          report_mismatch($sformatf("norm_z got %0d want %0d", out_data.norm_z, want.norm_z));
        if (out_data.zero_span_flags !== want.zero_span_flags)
          report_mismatch($sformatf("zero_span_flags got %b want %b",
                                    out_data.zero_span_flags, want.zero_span_flags));
      end
    end
  end

  // First sample seeds the extremes even with hold set; a second frozen
  // sample sits outside them but still meets a zero span.
  task automatic test_seed_under_hold();
    set_hold(1'b1);
    send_xyz(100, -5, 0);
    send_xyz(32767, -32768, 0);
    wait_for_drain();
  endtask

  // Release the hold and walk max up and min down on each axis.
  task automatic test_tracking();
    set_hold(1'b0);
    send_xyz(101, -6, 0);
    send_xyz(-32768, 32767, 1);
    send_xyz(32767, -32768, -1);
    send_xyz(0, 0, 0);
    send_xyz(-1, -1, 1);
    wait_for_drain();
  endtask

  // Gain at both ends of its range and at one.
  task automatic test_gain_extremes();
    write_register(REG_FULL_SCALE_GAIN, 16'd0);
    send_xyz(1234, -4321, 0);
    wait_for_drain();
    write_register(REG_FULL_SCALE_GAIN, 16'hffff);
    send_xyz(32767, -32768, 1);
    send_xyz(-32768, 32767, -1);
    wait_for_drain();
    write_register(REG_FULL_SCALE_GAIN, 16'd1);
    send_xyz(5, -5, 0);
    wait_for_drain();
  endtask

  // Freeze the narrow z span and push far outside it at top gain, so the
  // quotient overflows 24 bits both ways.
  task automatic test_saturation();
    set_hold(1'b1);
    write_register(REG_FULL_SCALE_GAIN, 16'hffff);
    send_xyz(32767, -32768, 32767);
    send_xyz(0, 0, -32768);
    send_xyz(-1, 1, 2);
    wait_for_drain();
    set_hold(1'b0);
    write_register(REG_FULL_SCALE_GAIN, GAIN_RESET);
  endtask

  // Long receiver hold-off while the sender offers without pause: the
  // block fills, parks its lanes and must stall its input.
  task automatic test_backpressure();
    int i;
    feed_gap_pct  = 0;
    drain_gap_pct = 0;
    -> hold_off_go;
    for (i = 0; i < 30; i++) send_xyz(random_axis(), random_axis(), random_axis());
    wait_for_drain();
  endtask

  // Pause the sender until everything owed has come back, then resume.
  task automatic test_drain_pause();
    int i;
    feed_gap_pct  = 20;
    drain_gap_pct = 20;
    for (i = 0; i < 20; i++) send_xyz(random_axis(), random_axis(), random_axis());
    in_valid <= 1'b0;
    while (pending_norms.size() != 0) @(negedge clk);
    for (i = 0; i < 20; i++) send_xyz(random_axis(), random_axis(), random_axis());
    wait_for_drain();
  endtask

  // Random samples in chunks, each chunk under a fresh hold and gain.
  task automatic test_random_traffic(int n_items, int feed_pct, int drain_pct);
    int chunk, i;
    logic [GAIN_W-1:0] g;
    feed_gap_pct  = feed_pct;
    drain_gap_pct = drain_pct;
    for (chunk = 0; chunk < 4; chunk++) begin
      wait_for_drain();
      case ($urandom_range(4))
        0: g = '0;
        1: g = '1;
        2: g = GAIN_W'(1);
        default: g = GAIN_W'($urandom);
      endcase
      write_register(REG_FULL_SCALE_GAIN, g);
      set_hold($urandom_range(3) == 0);
      for (i = 0; i < n_items / 4; i++) send_xyz(random_axis(), random_axis(), random_axis());
    end
    wait_for_drain();
  endtask

  initial begin
    // Synchronous reset, released at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_seed_under_hold();
    test_tracking();
    test_gain_extremes();
    test_saturation();
    test_backpressure();
    test_drain_pause();
    test_random_traffic(520, 11, 72);
    test_random_traffic(520, 72, 11);
    test_random_traffic(520, 0, 0);

    // Let any stray result show itself before the verdict.
    while (pending_norms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples, %0d results and %0d register writes,", samples_sent,
             results_seen, cfg_writes);
    $display("  with seeding under hold, saturation, gain extremes and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("minmax_axis_normalizer verification clean");
    end else begin
      $display("minmax_axis_normalizer verification failed");
    end
    $finish;
  end

endmodule
